@@ design/mbg_pkg.sv @@
`timescale 1ns / 1ps

package mbg_pkg;

    localparam int MAX_COLS   = 64;
    localparam int MAX_ROWS   = 64;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int SIZE_W     = 7;

    localparam logic [1:0] OP_RESTART = 2'd0;
    localparam logic [1:0] OP_STEP    = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_E = 2'd1;
    localparam logic [1:0] DIR_S = 2'd2;
    localparam logic [1:0] DIR_W = 2'd3;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_RESTARTED   = 3'd0,
        ST_CARVED      = 3'd1,
        ST_BACKTRACKED = 3'd2,
        ST_IDLE        = 3'd3,
        ST_READ        = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_BOOT,
        S_IDLE,
        S_RESTART,
        S_READ,
        S_TOP_RD,
        S_TOP,
        S_SCAN,
        S_CARVE,
        S_CARVE2,
        S_BACK,
        S_DONE
    } fsm_state_t;

    typedef struct packed {
        logic    latch_in;
        logic    clear_wr;
        logic    stack_rd;
        logic    take_top;
        logic    scan;
        logic    carve;
        logic    carve2;
        logic    back;
        logic    read;
        logic    load_res;
        status_t res_status;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic step_ok;
        logic found;
        logic scan_end;
        logic out_free;
    } sts_t;

    // Fisher-Yates over N,E,S,W, positions 3 down to 1.
    function automatic logic [3:0][1:0] shuffle_dirs(input logic [1:0] p4,
                                                     input logic [1:0] p3,
                                                     input logic       p2);
        logic [3:0][1:0] ord;
        logic [1:0]      t;
        logic [1:0]      j;
        begin
            ord[0] = DIR_N;
            ord[1] = DIR_E;
            ord[2] = DIR_S;
            ord[3] = DIR_W;
            t       = ord[3];
            ord[3]  = ord[p4];
            ord[p4] = t;
            j       = (p3 == 2'd3) ? 2'd2 : p3;
            t       = ord[2];
            ord[2]  = ord[j];
            ord[j]  = t;
            t       = ord[1];
            ord[1]  = ord[{1'b0, p2}];
            ord[{1'b0, p2}] = t;
            return ord;
        end
    endfunction

endpackage

@@ design/mbg_ctrl.sv @@
`timescale 1ns / 1ps

module mbg_ctrl
    import mbg_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_opcode,
    input  sts_t       sts,
    output cmd_t       cmd
);

    fsm_state_t state_reg, state_next;
    status_t    kind_reg, kind_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_BOOT;
            kind_reg  <= ST_IDLE;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        cmd            = '0;
        cmd.res_status = kind_reg;
        s_ready        = 1'b0;
        case (state_reg)
            S_BOOT: begin
                cmd.clear_wr = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch_in = 1'b1;
                    case (s_opcode)
                        OP_RESTART: begin
                            state_next = S_RESTART;
                            kind_next  = ST_RESTARTED;
                        end
                        OP_READ: begin
                            state_next = S_READ;
                            kind_next  = ST_READ;
                        end
                        OP_STEP: begin
                            if (sts.step_ok) begin
                                state_next = S_TOP_RD;
                            end else begin
                                state_next = S_DONE;
                                kind_next  = ST_IDLE;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                            kind_next  = ST_IDLE;
                        end
                    endcase
                end
            end
            S_RESTART: begin
                cmd.clear_wr = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_DONE;
                end
            end
            S_READ: begin
                cmd.read   = 1'b1;
                state_next = S_DONE;
            end
            S_TOP_RD: begin
                cmd.stack_rd = 1'b1;
                state_next   = S_TOP;
            end
            S_TOP: begin
                cmd.take_top = 1'b1;
                state_next   = S_SCAN;
            end
            S_SCAN: begin
                if (sts.found) begin
                    state_next = S_CARVE;
                end else if (sts.scan_end) begin
                    state_next = S_BACK;
                end else begin
                    cmd.scan = 1'b1;
                end
            end
            S_CARVE: begin
                cmd.carve  = 1'b1;
                state_next = S_CARVE2;
            end
            S_CARVE2: begin
                cmd.carve2 = 1'b1;
                kind_next  = ST_CARVED;
                state_next = S_DONE;
            end
            S_BACK: begin
                cmd.back   = 1'b1;
                kind_next  = ST_BACKTRACKED;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.load_res = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ design/mbg_datapath.sv @@
`timescale 1ns / 1ps

module mbg_datapath
    import mbg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wen,
    input  logic              cfg_index,
    input  logic [SIZE_W-1:0] cfg_wdata,
    input  logic [1:0]        s_pick_of_four,
    input  logic [1:0]        s_pick_of_three,
    input  logic              s_pick_of_two,
    input  logic [5:0]        s_query_col,
    input  logic [5:0]        s_query_row,
    input  logic              m_ready,
    output logic              m_valid,
    output logic [2:0]        m_status,
    output logic [5:0]        m_cell_col,
    output logic [5:0]        m_cell_row,
    output logic [1:0]        m_carve_dir,
    output logic [3:0]        m_wall_bits,
    output logic              m_cell_visited,
    output logic              m_cell_on_path,
    output logic [12:0]       m_visited_total,
    output logic [12:0]       m_depth_now,
    output logic              m_busy_res,
    input  cmd_t              cmd,
    output sts_t              sts
);

    // Storage.
    logic [3:0]        wall_mem  [CELL_COUNT];
    logic              vis_mem   [CELL_COUNT];
    logic              path_mem  [CELL_COUNT];
    logic [ADDR_W-1:0] stack_mem [CELL_COUNT];

    logic [3:0]        wall_rd_reg;
    logic              vis_rd_reg;
    logic              path_rd_reg;
    logic [ADDR_W-1:0] stack_rd_reg;

    // Configuration and generation state.
    logic [SIZE_W-1:0] width_reg, height_reg;
    logic [CNT_W-1:0]  depth_reg, vcount_reg;
    logic              running_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    // Latched request fields.
    logic [1:0]        p4_reg, p3_reg;
    logic              p2_reg;
    logic [COL_W-1:0]  qcol_reg;
    logic [ROW_W-1:0]  qrow_reg;

    // Step working registers.
    logic [COL_W-1:0]  cur_col_reg;
    logic [ROW_W-1:0]  cur_row_reg;
    logic [3:0][1:0]   order_reg;
    logic [2:0]        k_reg;
    logic              prev_inb_reg;
    logic [1:0]        prev_dir_reg;
    logic [COL_W-1:0]  prev_col_reg;
    logic [ROW_W-1:0]  prev_row_reg;

    // Result register.
    logic              m_valid_reg;
    status_t           res_status_reg;
    logic [5:0]        res_col_reg, res_row_reg;
    logic [1:0]        res_dir_reg;
    logic [3:0]        res_walls_reg;
    logic              res_vis_reg, res_onp_reg;
    logic [12:0]       res_vtot_reg, res_depth_reg;
    logic              res_busy_reg;

    logic [SIZE_W-1:0] eff_w, eff_h;
    logic [1:0]        cand_dir;
    logic [SIZE_W-1:0] cand_col7, cand_row7;
    logic              cand_neg, cand_inb;
    logic              cur_inb;
    logic [ADDR_W-1:0] cur_addr, prev_addr, cand_addr, qaddr, top_addr;

    logic              wall_we;
    logic [ADDR_W-1:0] wall_waddr;
    logic [3:0]        wall_mask, wall_wdata;
    logic              vis_we, vis_wdata, vis_re;
    logic [ADDR_W-1:0] vis_waddr, vis_raddr;
    logic              path_we, path_wdata;
    logic [ADDR_W-1:0] path_waddr;
    logic              stack_we;
    logic [ADDR_W-1:0] stack_waddr, stack_wdata;
    logic              depth_full;

    always_comb begin
        eff_w = (width_reg == '0) ? SIZE_W'(1)
              : ((width_reg > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : width_reg);
        eff_h = (height_reg == '0) ? SIZE_W'(1)
              : ((height_reg > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : height_reg);
    end

    assign cur_addr   = {cur_row_reg, cur_col_reg};
    assign prev_addr  = {prev_row_reg, prev_col_reg};
    assign qaddr      = {qrow_reg, qcol_reg};
    assign top_addr   = ADDR_W'(depth_reg - CNT_W'(1));
    assign depth_full = (depth_reg == CNT_W'(CELL_COUNT));
    assign cur_inb    = ({1'b0, cur_col_reg} < eff_w) && ({1'b0, cur_row_reg} < eff_h);

    // Neighbour for the scan position now being issued.
    always_comb begin
        cand_dir  = order_reg[k_reg[1:0]];
        cand_col7 = {1'b0, cur_col_reg};
        cand_row7 = {1'b0, cur_row_reg};
        cand_neg  = 1'b0;
        case (cand_dir)
            DIR_N: begin
                cand_neg  = (cur_row_reg == '0);
                cand_row7 = {1'b0, cur_row_reg} - SIZE_W'(1);
            end
            DIR_E: cand_col7 = {1'b0, cur_col_reg} + SIZE_W'(1);
            DIR_S: cand_row7 = {1'b0, cur_row_reg} + SIZE_W'(1);
            DIR_W: begin
                cand_neg  = (cur_col_reg == '0);
                cand_col7 = {1'b0, cur_col_reg} - SIZE_W'(1);
            end
            default: cand_neg = 1'b1;
        endcase
        cand_inb  = !cand_neg && (cand_col7 < eff_w) && (cand_row7 < eff_h);
        cand_addr = {cand_row7[ROW_W-1:0], cand_col7[COL_W-1:0]};
    end

    assign sts.clr_last = &clr_addr_reg;
    assign sts.step_ok  = running_reg && (depth_reg != '0);
    assign sts.found    = prev_inb_reg && !vis_rd_reg;
    assign sts.scan_end = k_reg[2];
    assign sts.out_free = !m_valid_reg || m_ready;

    // Write and read port selection.
    always_comb begin
        wall_we    = 1'b0;
        wall_waddr = clr_addr_reg;
        wall_mask  = 4'hF;
        wall_wdata = 4'hF;
        if (cmd.clear_wr) begin
            wall_we = 1'b1;
        end else if (cmd.carve) begin
            wall_we    = 1'b1;
            wall_waddr = cur_addr;
            wall_mask  = cur_inb ? (4'd1 << prev_dir_reg) : 4'd0;
            wall_wdata = 4'd0;
        end else if (cmd.carve2) begin
            wall_we    = 1'b1;
            wall_waddr = prev_addr;
            wall_mask  = cur_inb ? (4'd1 << (prev_dir_reg + 2'd2)) : 4'd0;
            wall_wdata = 4'd0;
        end

        vis_we    = cmd.clear_wr || cmd.carve;
        vis_waddr = cmd.clear_wr ? clr_addr_reg : prev_addr;
        vis_wdata = cmd.clear_wr ? (clr_addr_reg == '0) : 1'b1;
        vis_re    = (cmd.scan && !k_reg[2]) || cmd.read;
        vis_raddr = cmd.read ? qaddr : cand_addr;

        path_we    = cmd.clear_wr || cmd.take_top || cmd.back;
        path_waddr = cmd.clear_wr ? clr_addr_reg : (cmd.take_top ? stack_rd_reg : cur_addr);
        path_wdata = cmd.take_top;

        // The bottom entry is rewritten on the first cycle of a clearing pass.
        stack_we    = (cmd.clear_wr && (clr_addr_reg == '0)) || (cmd.carve && !depth_full);
        stack_waddr = cmd.clear_wr ? '0 : depth_reg[ADDR_W-1:0];
        stack_wdata = cmd.clear_wr ? '0 : prev_addr;
    end

    always_ff @(posedge aclk) begin
        for (int b = 0; b < 4; b++) begin
            if (wall_we && wall_mask[b]) begin
                wall_mem[wall_waddr][b] <= wall_wdata[b];
            end
        end
        if (cmd.read) begin
            wall_rd_reg <= wall_mem[qaddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (vis_we) begin
            vis_mem[vis_waddr] <= vis_wdata;
        end
        if (vis_re) begin
            vis_rd_reg <= vis_mem[vis_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (path_we) begin
            path_mem[path_waddr] <= path_wdata;
        end
        if (cmd.read) begin
            path_rd_reg <= path_mem[qaddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        if (cmd.stack_rd) begin
            stack_rd_reg <= stack_mem[top_addr];
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= SIZE_W'(40);
            height_reg   <= SIZE_W'(30);
            depth_reg    <= CNT_W'(1);
            vcount_reg   <= CNT_W'(1);
            running_reg  <= 1'b1;
            clr_addr_reg <= '0;
            k_reg        <= '0;
            prev_inb_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wen) begin
                if (cfg_index == CFG_WIDTH) begin
                    width_reg <= cfg_wdata;
                end else begin
                    height_reg <= cfg_wdata;
                end
            end
            if (cmd.clear_wr) begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == '0) begin
                    depth_reg   <= CNT_W'(1);
                    vcount_reg  <= CNT_W'(1);
                    running_reg <= 1'b1;
                end
            end
            if (cmd.take_top) begin
                k_reg        <= '0;
                prev_inb_reg <= 1'b0;
            end else if (cmd.scan && !k_reg[2]) begin
                k_reg        <= k_reg + 3'd1;
                prev_inb_reg <= cand_inb;
            end
            if (cmd.carve) begin
                vcount_reg <= vcount_reg + CNT_W'(1);
                if (!depth_full) begin
                    depth_reg <= depth_reg + CNT_W'(1);
                end
            end
            if (cmd.back) begin
                depth_reg <= depth_reg - CNT_W'(1);
                if (depth_reg == CNT_W'(1)) begin
                    running_reg <= 1'b0;
                end
            end
            if (cmd.load_res) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            p4_reg   <= s_pick_of_four;
            p3_reg   <= s_pick_of_three;
            p2_reg   <= s_pick_of_two;
            qcol_reg <= s_query_col;
            qrow_reg <= s_query_row;
        end
        if (cmd.take_top) begin
            cur_col_reg <= stack_rd_reg[COL_W-1:0];
            cur_row_reg <= stack_rd_reg[ADDR_W-1:COL_W];
            order_reg   <= shuffle_dirs(p4_reg, p3_reg, p2_reg);
        end
        if (cmd.scan && !k_reg[2]) begin
            prev_dir_reg <= cand_dir;
            prev_col_reg <= cand_col7[COL_W-1:0];
            prev_row_reg <= cand_row7[ROW_W-1:0];
        end
        if (cmd.load_res) begin
            res_status_reg <= cmd.res_status;
            res_col_reg    <= '0;
            res_row_reg    <= '0;
            res_dir_reg    <= '0;
            res_walls_reg  <= '0;
            res_vis_reg    <= 1'b0;
            res_onp_reg    <= 1'b0;
            case (cmd.res_status)
                ST_CARVED: begin
                    res_col_reg <= cur_col_reg;
                    res_row_reg <= cur_row_reg;
                    res_dir_reg <= prev_dir_reg;
                end
                ST_BACKTRACKED: begin
                    res_col_reg <= cur_col_reg;
                    res_row_reg <= cur_row_reg;
                end
                ST_READ: begin
                    res_col_reg   <= qcol_reg;
                    res_row_reg   <= qrow_reg;
                    res_walls_reg <= wall_rd_reg;
                    res_vis_reg   <= vis_rd_reg;
                    res_onp_reg   <= path_rd_reg;
                end
                default: begin
                end
            endcase
            res_vtot_reg  <= vcount_reg;
            res_depth_reg <= depth_reg;
            res_busy_reg  <= running_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = res_status_reg;
    assign m_cell_col      = res_col_reg;
    assign m_cell_row      = res_row_reg;
    assign m_carve_dir     = res_dir_reg;
    assign m_wall_bits     = res_walls_reg;
    assign m_cell_visited  = res_vis_reg;
    assign m_cell_on_path  = res_onp_reg;
    assign m_visited_total = res_vtot_reg;
    assign m_depth_now     = res_depth_reg;
    assign m_busy_res      = res_busy_reg;

`ifndef NO_ASSERTIONS
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= CNT_W'(CELL_COUNT))
        else $error("stack depth beyond the cell count");

    a_stopped_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !running_reg |-> (depth_reg == '0))
        else $error("generation stopped with cells left on the stack");

    a_count_covers_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        vcount_reg >= depth_reg)
        else $error("fewer visited cells than stack entries");

    a_carve_pushes: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.carve && !depth_full) |=> (depth_reg == $past(depth_reg) + CNT_W'(1)))
        else $error("carve did not push the new cell");
`endif

endmodule

@@ design/maze_backtracker_generator_unit.sv @@
`timescale 1ns / 1ps

// Depth-first maze generator over a grid of up to 64 x 64 cells.
// Input words (s_*) carry a request: restart, one generation step, or a
// cell read. Each accepted word yields exactly one result word on m_*.
// maze_width and maze_height are written through cfg_wen/cfg_index/cfg_wdata
// (index 0 width, index 1 height); the user must do so while no request is in
// flight, as the block itself does not enforce it. A carving or backtracking
// step runs a stack read, a top fetch, one to four neighbor probes of the
// visited store, then two wall writes through the single write port when a
// carve is made. A restart sweeps every cell of the store, one per cycle.
// One request is handled at a time; the next word is accepted once the
// current result sits in the output register, even if it has not been taken.
// After reset the same clearing pass runs with s_ready low;
// the grid then holds a fresh generation at 40 x 30.
// If the receiver stalls, the result holds on m_* and the next request,
// once accepted, waits after its work until the output register frees.

module maze_backtracker_generator_unit
    import mbg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [1:0]  s_pick_of_four,
    input  logic [1:0]  s_pick_of_three,
    input  logic        s_pick_of_two,
    input  logic [5:0]  s_query_col,
    input  logic [5:0]  s_query_row,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [5:0]  m_cell_col,
    output logic [5:0]  m_cell_row,
    output logic [1:0]  m_carve_dir,
    output logic [3:0]  m_wall_bits,
    output logic        m_cell_visited,
    output logic        m_cell_on_path,
    output logic [12:0] m_visited_total,
    output logic [12:0] m_depth_now,
    output logic        m_busy_res
);

    cmd_t cmd;
    sts_t sts;

    mbg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .sts      (sts),
        .cmd      (cmd)
    );

    mbg_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wen         (cfg_wen),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_pick_of_four  (s_pick_of_four),
        .s_pick_of_three (s_pick_of_three),
        .s_pick_of_two   (s_pick_of_two),
        .s_query_col     (s_query_col),
        .s_query_row     (s_query_row),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_status        (m_status),
        .m_cell_col      (m_cell_col),
        .m_cell_row      (m_cell_row),
        .m_carve_dir     (m_carve_dir),
        .m_wall_bits     (m_wall_bits),
        .m_cell_visited  (m_cell_visited),
        .m_cell_on_path  (m_cell_on_path),
        .m_visited_total (m_visited_total),
        .m_depth_now     (m_depth_now),
        .m_busy_res      (m_busy_res),
        .cmd             (cmd),
        .sts             (sts)
    );

endmodule
